// ===== rtl/rme_pkg.sv =====
// Shared types and constants for the rotation-matrix to Euler-angle block.
// Holds the CORDIC arctangent table, fixed-point widths and the pipeline side word.
// No dependencies.
package rme_pkg;

	localparam int IN_W     = 16;
	localparam int TBL_LEN  = 24;
	localparam int CW       = 36;
	localparam int ZW       = 28;
	localparam int SQW      = 62;
	localparam int SQ_STEPS = 31;

	localparam logic signed [IN_W-1:0] ONE_Q14     = 16'sd16384;
	localparam logic signed [ZW-1:0]   HALF_PI_Q24 = 28'sd26353589;
	localparam logic signed [ZW-1:0]   PI_Q13      = 28'sd25736;
	localparam logic signed [ZW-1:0]   HALF_PI_Q13 = 28'sd12868;

	localparam logic signed [ZW-1:0] ATAN_TBL [TBL_LEN] = '{
		28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
		28'sd1047214, 28'sd524117, 28'sd262123, 28'sd131069,
		28'sd65536, 28'sd32768, 28'sd16384, 28'sd8192,
		28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
		28'sd256, 28'sd128, 28'sd64, 28'sd32,
		28'sd16, 28'sd8, 28'sd4, 28'sd2
	};

	typedef struct packed {
		logic                   lock;
		logic                   sat_p;
		logic                   sat_n;
		logic signed [IN_W-1:0] ty;
		logic signed [IN_W-1:0] ax_y;
		logic signed [IN_W-1:0] ax_x;
		logic signed [IN_W-1:0] az_y;
		logic signed [IN_W-1:0] az_x;
	} side_t;

endpackage

// ===== rtl/rotation_matrix_to_euler.sv =====
// Rotation matrix to x-y-z Euler angles, fully pipelined.
// Square root and three CORDIC arctangent lanes; depends on rme_pkg.
//
// Usage:
//   Drive m00..m22 and raise start for one cycle per matrix word. busy is
//   always low, so a word is taken on every cycle that start is high.
//   Results appear on angle_x, angle_y, angle_z and gimbal_lock for exactly
//   one cycle, marked by done.
// Pipeline: one multiply stage, 31 square-root digit stages, one quadrant
//   stage, CORDIC_STAGES rotation stages and one output stage.
// Throughput: one word per cycle; every stage is a register with its own
//   valid bit and all three arctangents run in parallel lanes.
// Reset: arst_n clears every valid bit; words in flight are dropped and no
//   done pulse follows until new words enter.
// The receiver cannot stall; results are shown once and not held.
// Gimbal lock (m20 exactly plus or minus one) sets gimbal_lock, forces
//   angle_z to zero and takes angle_x from m01 and m02.
module rotation_matrix_to_euler #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [15:0]  m00,
	input  logic signed [15:0]  m01,
	input  logic signed [15:0]  m02,
	input  logic signed [15:0]  m10,
	input  logic signed [15:0]  m20,
	input  logic signed [15:0]  m21,
	input  logic signed [15:0]  m22,
	output logic                done,
	output logic signed [15:0]  angle_x,
	output logic signed [14:0]  angle_y,
	output logic signed [15:0]  angle_z,
	output logic                gimbal_lock
);

	localparam int CW   = rme_pkg::CW;
	localparam int ZW   = rme_pkg::ZW;
	localparam int SQW  = rme_pkg::SQW;
	localparam int SQN  = rme_pkg::SQ_STEPS;

	function automatic logic signed [15:0] to_q13(input logic signed [ZW-1:0] z,
		input logic signed [ZW-1:0] lim);
		logic signed [ZW-1:0] t;
		t = (z + ZW'(1024)) >>> 11;
		if (t > lim) t = lim;
		if (t < -lim) t = -lim;
		return t[15:0];
	endfunction

	assign busy = 1'b0;

	// multiply stage
	logic                   vld_s1;
	rme_pkg::side_t         sd_s1;
	logic [28:0]            rr_s1;
	logic signed [31:0]     tsq;
	logic signed [32:0]     rdiff;
	logic                   lock_in;

	assign tsq     = m20 * m20;
	assign rdiff   = 33'sd268435456 - 33'(tsq);
	assign lock_in = (m20 == rme_pkg::ONE_Q14) || (m20 == -rme_pkg::ONE_Q14);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= start;
	end

	always_ff @(posedge clk) begin
		rr_s1       <= rdiff[28:0];
		sd_s1.lock  <= lock_in;
		sd_s1.sat_p <= m20 >= rme_pkg::ONE_Q14;
		sd_s1.sat_n <= m20 <= -rme_pkg::ONE_Q14;
		sd_s1.ty    <= m20;
		sd_s1.ax_y  <= lock_in ? m01 : m21;
		sd_s1.ax_x  <= lock_in ? m02 : m22;
		sd_s1.az_y  <= m10;
		sd_s1.az_x  <= m00;
	end

	// square root digit stages
	logic [SQW-1:0]  sv_s  [0:SQN];
	logic [SQW-1:0]  sr_s  [0:SQN];
	rme_pkg::side_t  ssd_s [0:SQN];
	logic            svld_s[0:SQN];

	assign sv_s[0]   = {1'b0, rr_s1, 32'b0};
	assign sr_s[0]   = '0;
	assign ssd_s[0]  = sd_s1;
	assign svld_s[0] = vld_s1;

	for (genvar j = 0; j < SQN; j++) begin : g_sqrt
		localparam logic [SQW-1:0] B = SQW'(1) << (2 * (SQN - 1 - j));
		logic [SQW-1:0] trial;
		assign trial = sr_s[j] + B;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) svld_s[j+1] <= 1'b0;
			else svld_s[j+1] <= svld_s[j];
		end
		always_ff @(posedge clk) begin
			ssd_s[j+1] <= ssd_s[j];
			if (sv_s[j] >= trial) begin
				sv_s[j+1] <= sv_s[j] - trial;
				sr_s[j+1] <= (sr_s[j] >> 1) + B;
			end else begin
				sv_s[j+1] <= sv_s[j];
				sr_s[j+1] <= sr_s[j] >> 1;
			end
		end
	end

	// quadrant stage and CORDIC lanes: 0 asin, 1 angle x, 2 angle z
	logic signed [CW-1:0] cx_s  [0:CORDIC_STAGES][0:2];
	logic signed [CW-1:0] cy_s  [0:CORDIC_STAGES][0:2];
	logic signed [ZW-1:0] cz_s  [0:CORDIC_STAGES][0:2];
	logic                 czr_s [0:CORDIC_STAGES][0:2];
	rme_pkg::side_t       csd_s [0:CORDIC_STAGES];
	logic                 cvld_s[0:CORDIC_STAGES];

	logic signed [CW-1:0] px [0:2];
	logic signed [CW-1:0] py [0:2];
	rme_pkg::side_t       sq_sd;

	assign sq_sd = ssd_s[SQN];
	assign py[0] = CW'($signed({sq_sd.ty, 16'b0}));
	assign px[0] = CW'(sr_s[SQN][30:0]);
	assign py[1] = CW'($signed({sq_sd.ax_y, 16'b0}));
	assign px[1] = CW'($signed({sq_sd.ax_x, 16'b0}));
	assign py[2] = CW'($signed({sq_sd.az_y, 16'b0}));
	assign px[2] = CW'($signed({sq_sd.az_x, 16'b0}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cvld_s[0] <= 1'b0;
		else cvld_s[0] <= svld_s[SQN];
	end

	always_ff @(posedge clk) begin
		csd_s[0] <= sq_sd;
	end

	for (genvar l = 0; l < 3; l++) begin : g_quad
		always_ff @(posedge clk) begin
			czr_s[0][l] <= (px[l] == '0) && (py[l] == '0);
			if (px[l] < 0) begin
				if (py[l] >= 0) begin
					cx_s[0][l] <= py[l];
					cy_s[0][l] <= -px[l];
					cz_s[0][l] <= rme_pkg::HALF_PI_Q24;
				end else begin
					cx_s[0][l] <= -py[l];
					cy_s[0][l] <= px[l];
					cz_s[0][l] <= -rme_pkg::HALF_PI_Q24;
				end
			end else begin
				cx_s[0][l] <= px[l];
				cy_s[0][l] <= py[l];
				cz_s[0][l] <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cvld_s[i+1] <= 1'b0;
			else cvld_s[i+1] <= cvld_s[i];
		end
		always_ff @(posedge clk) begin
			csd_s[i+1] <= csd_s[i];
		end
		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic signed [CW-1:0] xs;
			logic signed [CW-1:0] ys;
			assign xs = cx_s[i][l] >>> i;
			assign ys = cy_s[i][l] >>> i;
			always_ff @(posedge clk) begin
				czr_s[i+1][l] <= czr_s[i][l];
				if (cy_s[i][l] >= 0) begin
					cx_s[i+1][l] <= cx_s[i][l] + ys;
					cy_s[i+1][l] <= cy_s[i][l] - xs;
					cz_s[i+1][l] <= cz_s[i][l] + rme_pkg::ATAN_TBL[i];
				end else begin
					cx_s[i+1][l] <= cx_s[i][l] - ys;
					cy_s[i+1][l] <= cy_s[i][l] + xs;
					cz_s[i+1][l] <= cz_s[i][l] - rme_pkg::ATAN_TBL[i];
				end
			end
		end
	end

	// output stage
	rme_pkg::side_t       fsd;
	logic signed [ZW-1:0] za [0:2];
	logic signed [ZW-1:0] asin_v;
	logic signed [15:0]   ay_w;
	logic                 done_q;
	logic signed [15:0]   ax_q;
	logic signed [14:0]   ay_q;
	logic signed [15:0]   az_q;
	logic                 lock_q;

	assign fsd = csd_s[CORDIC_STAGES];

	for (genvar l = 0; l < 3; l++) begin : g_zero
		assign za[l] = czr_s[CORDIC_STAGES][l] ? '0 : cz_s[CORDIC_STAGES][l];
	end

	always_comb begin
		if (fsd.sat_p) asin_v = rme_pkg::HALF_PI_Q24;
		else if (fsd.sat_n) asin_v = -rme_pkg::HALF_PI_Q24;
		else asin_v = za[0];
		ay_w = to_q13(-asin_v, rme_pkg::HALF_PI_Q13);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= cvld_s[CORDIC_STAGES];
	end

	always_ff @(posedge clk) begin
		ax_q   <= to_q13(za[1], rme_pkg::PI_Q13);
		ay_q   <= ay_w[14:0];
		az_q   <= fsd.lock ? '0 : to_q13(za[2], rme_pkg::PI_Q13);
		lock_q <= fsd.lock;
	end

	assign done        = done_q;
	assign angle_x     = ax_q;
	assign angle_y     = ay_q;
	assign angle_z     = az_q;
	assign gimbal_lock = lock_q;

	a_lock_z : assert property (@(posedge clk) disable iff (!arst_n)
		done && gimbal_lock |-> angle_z == 16'sd0)
		else $error("angle_z not zero under gimbal lock");

	a_lock_y : assert property (@(posedge clk) disable iff (!arst_n)
		done && gimbal_lock |-> (angle_y == 15'sd12868 || angle_y == -15'sd12868))
		else $error("angle_y not at a pole under gimbal lock");

	a_x_range : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (angle_x <= 16'sd25736 && angle_x >= -16'sd25736))
		else $error("angle_x out of range");

endmodule

// ===== sim/tb_rotation_matrix_to_euler.sv =====
// Testbench for rotation_matrix_to_euler: directed rows, then random matrices,
// each result checked against listed angles or a built-in fixed-point CORDIC Euler predictor.
// Depends on rme_pkg and rotation_matrix_to_euler.
module tb_rotation_matrix_to_euler;

	localparam int STAGES = 16;
	localparam int LATENCY = STAGES + 34;
	localparam int N_RANDOM = 1130;
	localparam longint CYCLE_LIMIT = 200000;
	localparam longint Q24_HALF_PI = 26353589;
	localparam longint Q13_PI = 25736;
	localparam longint Q13_HALF_PI = 12868;
	localparam longint Q14_ONE = 16384;

	typedef struct {
		logic signed [15:0] m00, m01, m02, m10, m20, m21, m22;
	} matrix_t;

	typedef struct {
		logic signed [15:0] ax;
		logic signed [14:0] ay;
		logic signed [15:0] az;
		logic               lock;
	} euler_t;

	typedef struct {
		matrix_t m;
		bit      known;
		euler_t  e;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic signed [15:0] m00 = 0, m01 = 0, m02 = 0, m10 = 0, m20 = 0, m21 = 0, m22 = 0;
	logic done;
	logic signed [15:0] angle_x;
	logic signed [14:0] angle_y;
	logic signed [15:0] angle_z;
	logic gimbal_lock;

	euler_t pending_angles[$];
	row_t   directed_rows[$];
	int     fail_count = 0;
	longint cycle_count = 0;

	rotation_matrix_to_euler #(.CORDIC_STAGES(STAGES)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m20(m20), .m21(m21), .m22(m22),
		.done(done), .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
		.gimbal_lock(gimbal_lock)
	);

	always #2 clk = ~clk;

	function automatic longint floor_shift(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint atan_step(int i);
		return longint'(rme_pkg::ATAN_TBL[i]);
	endfunction

	function automatic longint cordic_angle(longint y, longint x);
		longint z, t, xs, ys;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = Q24_HALF_PI;
			end else begin
				t = x; x = -y; y = t; z = -Q24_HALF_PI;
			end
		end
		for (int i = 0; i < STAGES && i < rme_pkg::TBL_LEN; i++) begin
			xs = floor_shift(x, i);
			ys = floor_shift(y, i);
			if (y >= 0) begin
				x += ys; y -= xs; z += atan_step(i);
			end else begin
				x -= ys; y += xs; z -= atan_step(i);
			end
		end
		return z;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint arcsine_q24(longint t);
		longint unsigned r;
		if (t >= Q14_ONE)
			return Q24_HALF_PI;
		if (t <= -Q14_ONE)
			return -Q24_HALF_PI;
		r = longint'(Q14_ONE * Q14_ONE - t * t);
		return cordic_angle(t * 65536, int_sqrt(r << 32));
	endfunction

	function automatic longint round_q13(longint z, longint lim);
		longint v;
		v = floor_shift(z + 1024, 11);
		if (v > lim) v = lim;
		if (v < -lim) v = -lim;
		return v;
	endfunction

	function automatic longint angle_q13(longint y, longint x);
		return round_q13(cordic_angle(y * 65536, x * 65536), Q13_PI);
	endfunction

	function automatic euler_t predict_euler(matrix_t m);
		euler_t e;
		if (m.m20 == Q14_ONE || m.m20 == -Q14_ONE) begin
			e.lock = 1'b1;
			e.az = '0;
			e.ay = 15'((m.m20 == Q14_ONE) ? -Q13_HALF_PI : Q13_HALF_PI);
			e.ax = 16'(angle_q13(m.m01, m.m02));
		end else begin
			e.lock = 1'b0;
			e.ay = 15'(round_q13(-arcsine_q24(m.m20), Q13_HALF_PI));
			e.ax = 16'(angle_q13(m.m21, m.m22));
			e.az = 16'(angle_q13(m.m10, m.m00));
		end
		return e;
	endfunction

	function automatic logic signed [15:0] rand_entry();
		case ($urandom_range(0, 9))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return '0;
			3: return 16'($urandom_range(0, 65535));
			default: return 16'($signed(16'($urandom_range(0, 32768))) - 16'sd16384);
		endcase
	endfunction

	function automatic matrix_t rand_matrix();
		matrix_t m;
		m.m00 = rand_entry(); m.m01 = rand_entry(); m.m02 = rand_entry();
		m.m10 = rand_entry(); m.m21 = rand_entry(); m.m22 = rand_entry();
		case ($urandom_range(0, 7))
			0: m.m20 = 16'sd16384;
			1: m.m20 = -16'sd16384;
			default: m.m20 = rand_entry();
		endcase
		return m;
	endfunction

	function automatic row_t mk_row(int a, int b, int c, int d, int e20, int f, int g,
			bit known, int ex, int ey, int ez, bit lk);
		row_t r;
		r.m = '{16'(a), 16'(b), 16'(c), 16'(d), 16'(e20), 16'(f), 16'(g)};
		r.known = known;
		r.e = '{16'(ex), 15'(ey), 16'(ez), lk};
		return r;
	endfunction

	task automatic send_word(matrix_t m, euler_t e);
		m00 <= m.m00; m01 <= m.m01; m02 <= m.m02; m10 <= m.m10;
		m20 <= m.m20; m21 <= m.m21; m22 <= m.m22;
		start <= 1;
		do @(posedge clk); while (busy);
		pending_angles.push_back(e);
		@(negedge clk);
	endtask

	task automatic idle_gap(bit allow);
		if (allow && $urandom_range(0, 5) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** rotation_matrix_to_euler: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		euler_t e;
		if (arst_n && done) begin
			if (pending_angles.size() == 0) begin
				$error("result with no word pending");
				fail_count++;
			end else begin
				e = pending_angles.pop_front();
				if (angle_x !== e.ax) begin
					$error("angle_x expected %0d got %0d", e.ax, angle_x); fail_count++;
				end
				if (angle_y !== e.ay) begin
					$error("angle_y expected %0d got %0d", e.ay, angle_y); fail_count++;
				end
				if (angle_z !== e.az) begin
					$error("angle_z expected %0d got %0d", e.az, angle_z); fail_count++;
				end
				if (gimbal_lock !== e.lock) begin
					$error("gimbal_lock expected %0d got %0d", e.lock, gimbal_lock);
					fail_count++;
				end
			end
		end
	end

	initial begin
		row_t   r;
		euler_t e;
		int     waited;
		// identity, extremes, both lock signs, zero operands, negative x, saturation
		directed_rows.push_back(mk_row(16384, 0, 0, 0, 0, 0, 16384, 1, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(5, 0, 16384, 7, 16384, 0, 0, 1, 0, -12868, 0, 1));
		directed_rows.push_back(mk_row(5, 0, 0, 7, -16384, 0, 0, 1, 0, 12868, 0, 1));
		directed_rows.push_back(mk_row(0, 16384, -16384, 0, 16384, 3, 3, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(0, -16384, -16384, 0, -16384, 3, 3, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(-16384, 0, 0, 0, 0, 0, -16384, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(-16384, 0, 0, -1, 0, -1, -16384, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(-16384, 0, 0, 1, 0, 1, -16384, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(0, 0, 0, 16384, 16383, 16384, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(0, 0, 0, -16384, -16383, -16384, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(1, 0, 0, 1, 16385, 1, 1, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(1, 0, 0, 1, -16385, 1, 1, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(-32768, 0, 0, 32767, 32767, -32768, 32767, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(32767, -32768, 32767, -32768, -32768, 32767, -32768,
			0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(11585, 0, 0, 11585, 8192, 11585, 11585, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(-1, 7, -9, 1, 1, -1, 1, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk_row(16384, -32768, -32768, 0, 16384, 0, 0, 0, 0, 0, 0, 0));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			e = r.known ? r.e : predict_euler(r.m);
			send_word(r.m, e);
			idle_gap(1);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			r.m = rand_matrix();
			send_word(r.m, predict_euler(r.m));
			idle_gap(i < N_RANDOM - 150);
		end
		start <= 0;

		waited = 0;
		while (pending_angles.size() != 0 && waited < 20 * LATENCY) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY) @(posedge clk);
		if (fail_count == 0 && pending_angles.size() == 0)
			$display("** rotation_matrix_to_euler: PASSED **");
		else
			$display("** rotation_matrix_to_euler: FAILED **");
		$finish;
	end

endmodule
